### hw/rtl/mie_pkg.sv
// Shared types and constants for the modular inverse unit.
// No dependencies; imported by modular_inverse_euclid_unit.
`timescale 1ns / 1ps
`default_nettype none

package mie_pkg;

  // Width of the modulus register and of the value and inverse ports
  localparam int unsigned FieldWidth = 16;

  // Modulus after reset
  localparam logic [FieldWidth-1:0] ModulusReset = 16'd26;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_REDUCE = 5'b00010,
    ST_STEP   = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_DONE   = 5'b10000
  } mie_state_e;

endpackage

`default_nettype wire

### hw/rtl/modular_inverse_euclid_unit.sv
// Modular inverse by the iterative extended Euclidean algorithm.
// One shared restoring divider with a shift-add cofactor accumulator, run by a
// small sequencer. Depends on mie_pkg.
`timescale 1ns / 1ps
`default_nettype none

//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | input     | in_valid_i / in_stall_o | value_i[15:0]
//  out     | output    | out_valid_o/out_stall_i | inverse_o[15:0], status_o
//  cfg     | input     | cfg_we_i                | cfg_wdata_i[15:0] (modulus)
//
// Each word is reduced mod n, then runs k Euclid steps (about 23 at most for
// 16-bit operands); each step uses the bit-per-cycle divider, one quotient
// bit and one cofactor add per cycle.
// Reset clears control state and loads the modulus with 26.
// in_stall_o is high from acceptance until the result is registered; a new
// word may enter while the previous result still waits on out_stall_i.
module modular_inverse_euclid_unit
  import mie_pkg::*;
#(
  parameter int unsigned WIDTH = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [FieldWidth-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [FieldWidth-1:0] value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [FieldWidth-1:0] inverse_o,
  output logic                       status_o
);

  localparam int unsigned TW = WIDTH + 2;
  localparam int unsigned CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  mie_state_e state_q, state_d;

  logic [FieldWidth-1:0] modulus_q;

  logic [WIDTH-1:0]        n_q, n_d;
  logic [WIDTH-1:0]        r_prev_q, r_prev_d;
  logic [WIDTH-1:0]        r_cur_q, r_cur_d;
  logic signed [TW-1:0]    t_prev_q, t_prev_d;
  logic signed [TW-1:0]    t_cur_q, t_cur_d;
  logic [WIDTH-1:0]        dvd_q, dvd_d;
  logic [WIDTH-1:0]        rem_q, rem_d;
  logic signed [TW-1:0]    acc_q, acc_d;
  logic [CW-1:0]           cnt_q, cnt_d;

  logic                  out_valid_q, out_valid_d;
  logic [FieldWidth-1:0] inverse_q, inverse_d;
  logic                  status_q, status_d;

  logic                  in_accept;
  logic                  out_free;
  logic [WIDTH-1:0]      value_w;
  logic [WIDTH-1:0]      modulus_w;
  logic [WIDTH-1:0]      divisor;
  logic [WIDTH:0]        rem_shift;
  logic                  q_bit;
  logic [WIDTH:0]        rem_next;
  logic signed [TW-1:0]  acc_next;
  logic                  div_last;
  logic signed [TW-1:0]  n_s;
  logic signed [TW-1:0]  t_wrap;
  logic [WIDTH-1:0]      inv_w;

  // Hold the modulus register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModulusReset;
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign value_w   = WIDTH'(value_i);
  assign modulus_w = WIDTH'(modulus_q);

  // Shared divider step: one quotient bit, one cofactor shift-add
  assign divisor   = (state_q == ST_REDUCE) ? r_prev_q : r_cur_q;
  assign rem_shift = {rem_q, dvd_q[WIDTH-1]};
  assign q_bit     = (rem_shift >= {1'b0, divisor});
  assign rem_next  = q_bit ? (rem_shift - {1'b0, divisor}) : rem_shift;
  assign acc_next  = (acc_q <<< 1) + (q_bit ? t_cur_q : TW'(0));
  assign div_last  = (cnt_q == CW'(WIDTH - 1));

  // Wrap the final cofactor into 0..n-1
  assign n_s    = $signed({2'b00, n_q});
  assign t_wrap = t_prev_q[TW-1] ? (t_prev_q + n_s)
                : ((t_prev_q >= n_s) ? (t_prev_q - n_s) : t_prev_q);
  assign inv_w  = t_wrap[WIDTH-1:0];

  // Sequence the reduction, the Euclid steps and the result
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    r_prev_d    = r_prev_q;
    r_cur_d     = r_cur_q;
    t_prev_d    = t_prev_q;
    t_cur_d     = t_cur_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    inverse_d   = inverse_q;
    status_d    = status_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          n_d      = modulus_w;
          t_prev_d = TW'(0);
          t_cur_d  = TW'(1);
          dvd_d    = value_w;
          rem_d    = '0;
          acc_d    = '0;
          cnt_d    = '0;
          if (modulus_w < WIDTH'(2)) begin
            // no invertible elements: gcd test fails at once
            r_prev_d = '0;
            r_cur_d  = '0;
            state_d  = ST_STEP;
          end else begin
            r_prev_d = modulus_w;
            state_d  = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        // value mod n, quotient discarded
        dvd_d = dvd_q << 1;
        rem_d = rem_next[WIDTH-1:0];
        cnt_d = cnt_q + CW'(1);
        if (div_last) begin
          r_cur_d = rem_next[WIDTH-1:0];
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (r_cur_q == '0) begin
          state_d = ST_DONE;
        end else begin
          dvd_d   = r_prev_q;
          rem_d   = '0;
          acc_d   = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        dvd_d = dvd_q << 1;
        rem_d = rem_next[WIDTH-1:0];
        acc_d = acc_next;
        cnt_d = cnt_q + CW'(1);
        if (div_last) begin
          // advance the remainder and cofactor pairs
          r_prev_d = r_cur_q;
          r_cur_d  = rem_next[WIDTH-1:0];
          t_prev_d = t_cur_q;
          t_cur_d  = t_prev_q - acc_next;
          state_d  = ST_STEP;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (r_prev_q == WIDTH'(1)) begin
            inverse_d = FieldWidth'(inv_w);
            status_d  = 1'b0;
          end else begin
            inverse_d = '0;
            status_d  = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    r_prev_q  <= r_prev_d;
    r_cur_q   <= r_cur_d;
    t_prev_q  <= t_prev_d;
    t_cur_q   <= t_cur_d;
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    acc_q     <= acc_d;
    inverse_q <= inverse_d;
    status_q  <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign inverse_o   = inverse_q;
  assign status_o    = status_q;

`ifndef SYNTH
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q != ST_IDLE))
    else $error("sequencer idle right after accepting a word");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (r_cur_q != '0))
    else $error("Euclid step dividing by zero");

  a_inverse_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !status_o) |-> (inverse_o != '0))
    else $error("zero inverse reported as found");
`endif

endmodule

`default_nettype wire
